// ===== design/kcq_pkg.sv =====
`default_nettype none

package kcq_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    localparam int TAG_BITS = 32;
    localparam int REV_BITS = 32;
    localparam int PAY_PORT_BITS = 64;

    // per-cell control, decoded in the top level for each cell
    typedef struct packed {
        logic load;
        logic search;
        logic remove;
        logic occupied;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== design/kcq_req_if.sv =====
`default_nettype none

interface kcq_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] sequence_tag;
    logic        is_response;
    logic [63:0] payload;

    modport source (output valid, operation, sequence_tag, is_response, payload,
                    input ready);
    modport sink   (input valid, operation, sequence_tag, is_response, payload,
                    output ready);
endinterface

`default_nettype wire

// ===== design/kcq_rsp_if.sv =====
`default_nettype none

interface kcq_rsp_if #(
    parameter int CNT_W = 5
);
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [31:0]        taken_tag;
    logic [63:0]        taken_payload;
    logic [CNT_W-1:0]   entry_count;
    logic [31:0]        revision_out;

    modport source (output valid, status, taken_tag, taken_payload, entry_count,
                    revision_out, input ready);
    modport sink   (input valid, status, taken_tag, taken_payload, entry_count,
                    revision_out, output ready);
endinterface

`default_nettype wire

// ===== design/keyed_response_holding_queue_core.sv =====
`default_nettype none

// channel   dir  handshake      payload
// i_req     in   valid/ready    operation, sequence_tag, is_response, payload
// o_rsp     out  valid/ready    status, taken_tag, taken_payload, entry_count,
//                               revision_out
//
// push and rejected requests answer directly; for a take, all cells
// compare the tag in parallel, then the oldest hit is unloaded and the cells
// above it shift down one slot. a new request is taken once the previous
// result has left or is leaving the output register. synchronous active-low
// reset empties the queue and sets the revision to one; no clearing pass.

module keyed_response_holding_queue_core #(
    parameter int DEPTH        = 16,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    kcq_req_if.sink    i_req,
    kcq_rsp_if.source  o_rsp
);
    import kcq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_TAKE
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    logic [REV_BITS-1:0]     r_rev;
    logic                    r_rsp_valid;
    logic                    n_rsp_valid;
    t_status                 r_status;
    logic [TAG_BITS-1:0]     r_taken_tag;
    logic [PAYLOAD_BITS-1:0] r_taken_payload;

    logic                    w_accept;
    logic                    w_bad;
    logic                    w_full;
    logic                    w_push_ok;
    logic                    w_found;
    logic [PAYLOAD_BITS-1:0] w_in_payload;

    logic [DEPTH:0]          w_hit_chain;
    logic [DEPTH-1:0]        w_first;
    logic [TAG_BITS-1:0]     w_tk_tag [DEPTH+1];
    logic [PAYLOAD_BITS-1:0] w_tk_pay [DEPTH+1];
    logic [TAG_BITS-1:0]     w_cell_tag [DEPTH+1];
    logic [PAYLOAD_BITS-1:0] w_cell_pay [DEPTH+1];

    assign w_accept     = i_req.valid & i_req.ready;
    assign i_req.ready  = (r_state == S_IDLE) & (~r_rsp_valid | o_rsp.ready);
    assign w_in_payload = i_req.payload[PAYLOAD_BITS-1:0];
    assign w_bad        = (i_req.sequence_tag == '0) |
                          ((i_req.operation == OP_PUSH) & ~i_req.is_response);
    assign w_full       = (r_count == CNT_W'(DEPTH));
    assign w_push_ok    = w_accept & ~w_bad & (i_req.operation == OP_PUSH) & ~w_full;
    assign w_found      = w_hit_chain[DEPTH];

    // a valid take answers from S_TAKE, everything else answers at once
    assign n_rsp_valid  = (r_state == S_TAKE) |
                          ((r_state == S_IDLE) & w_accept &
                           (w_bad | (i_req.operation != OP_TAKE))) |
                          (r_rsp_valid & ~o_rsp.ready);

    assign w_hit_chain[0] = 1'b0;
    assign w_tk_tag[0]    = '0;
    assign w_tk_pay[0]    = '0;
    // vacated top slot refills with zero
    assign w_cell_tag[DEPTH] = '0;
    assign w_cell_pay[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;

        assign w_ctl.load     = w_push_ok & (r_count == CNT_W'(g));
        assign w_ctl.search   = w_accept & ~w_bad & (i_req.operation == OP_TAKE);
        assign w_ctl.remove   = (r_state == S_TAKE);
        assign w_ctl.occupied = (CNT_W'(g) < r_count);
        assign w_first[g]     = w_hit_chain[g+1] & ~w_hit_chain[g];

        kcq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl),
            .i_tag           (i_req.sequence_tag),
            .i_payload       (w_in_payload),
            .i_up_tag        (w_cell_tag[g+1]),
            .i_up_payload    (w_cell_pay[g+1]),
            .i_hit_below     (w_hit_chain[g]),
            .o_hit_below     (w_hit_chain[g+1]),
            .i_taken_tag     (w_tk_tag[g]),
            .i_taken_payload (w_tk_pay[g]),
            .o_taken_tag     (w_tk_tag[g+1]),
            .o_taken_payload (w_tk_pay[g+1]),
            .o_tag           (w_cell_tag[g]),
            .o_payload       (w_cell_pay[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rev       <= REV_BITS'(1);
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_taken_tag     <= '0;
                        r_taken_payload <= '0;
                        priority if (w_bad) begin
                            r_status <= ST_INVALID;
                        end else if (i_req.operation == OP_TAKE) begin
                            r_state <= S_TAKE;
                        end else if (w_full) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_OK;
                            r_count  <= r_count + CNT_W'(1);
                            r_rev    <= r_rev + REV_BITS'(1);
                        end
                    end
                end
                S_TAKE: begin
                    r_state <= S_IDLE;
                    if (w_found) begin
                        r_status        <= ST_OK;
                        r_taken_tag     <= w_tk_tag[DEPTH];
                        r_taken_payload <= w_tk_pay[DEPTH];
                        r_count         <= r_count - CNT_W'(1);
                        r_rev           <= r_rev + REV_BITS'(1);
                    end else begin
                        r_status <= ST_NOT_FOUND;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid         = r_rsp_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.taken_tag     = r_taken_tag;
    assign o_rsp.taken_payload = PAY_PORT_BITS'(r_taken_payload);
    assign o_rsp.entry_count   = r_count;
    assign o_rsp.revision_out  = r_rev;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_one_oldest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAKE) |-> $onehot0(w_first))
        else $error("more than one cell picked as oldest match");

    a_take_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_bad && i_req.operation == OP_TAKE |=> r_state == S_TAKE && !r_rsp_valid)
        else $error("take did not enter search cycle with an empty output");
`endif

endmodule

`default_nettype wire

// ===== design/kcq_cell.sv =====
`default_nettype none

module kcq_cell #(
    parameter int PAYLOAD_BITS = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire kcq_pkg::t_cell_ctl      i_ctl,
    input  wire [kcq_pkg::TAG_BITS-1:0]  i_tag,
    input  wire [PAYLOAD_BITS-1:0]       i_payload,
    input  wire [kcq_pkg::TAG_BITS-1:0]  i_up_tag,
    input  wire [PAYLOAD_BITS-1:0]       i_up_payload,
    input  wire                          i_hit_below,
    output logic                         o_hit_below,
    input  wire [kcq_pkg::TAG_BITS-1:0]  i_taken_tag,
    input  wire [PAYLOAD_BITS-1:0]       i_taken_payload,
    output logic [kcq_pkg::TAG_BITS-1:0] o_taken_tag,
    output logic [PAYLOAD_BITS-1:0]      o_taken_payload,
    output logic [kcq_pkg::TAG_BITS-1:0] o_tag,
    output logic [PAYLOAD_BITS-1:0]      o_payload
);
    import kcq_pkg::*;

    logic [TAG_BITS-1:0]     r_tag;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic                    r_hit;
    logic                    w_first;
    logic                    w_shift;

    // oldest match is the first hit with no hit below it
    assign w_first     = r_hit & ~i_hit_below;
    assign o_hit_below = i_hit_below | r_hit;
    assign w_shift     = i_ctl.remove & o_hit_below;

    assign o_taken_tag     = i_taken_tag | (w_first ? r_tag : '0);
    assign o_taken_payload = i_taken_payload | (w_first ? r_payload : '0);

    assign o_tag     = r_tag;
    assign o_payload = r_payload;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_tag     <= i_tag;
            r_payload <= i_payload;
        end else if (w_shift) begin
            r_tag     <= i_up_tag;
            r_payload <= i_up_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= i_ctl.search & i_ctl.occupied & (r_tag == i_tag);
        end
    end

endmodule

`default_nettype wire

// ===== bench/tb_keyed_response_holding_queue_core.sv =====
`timescale 1ns / 100ps

module tb_keyed_response_holding_queue_core;
    import kcq_pkg::*;

    localparam int HOLD_DEPTH = 16;
    localparam int RANDOM_ITEMS = 1550;
    localparam int SEGMENT_ITEMS = 130;

    typedef struct {
        logic        op;
        logic [31:0] tag;
        logic        is_resp;
        logic [63:0] payload;
        int unsigned mode;
        bit          drain;
    } req_item_t;

    typedef struct packed {
        t_status     status;
        logic [31:0] tag;
        logic [63:0] payload;
        logic [4:0]  count;
        logic [31:0] revision;
    } rsp_fields_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    kcq_req_if req_if ();
    kcq_rsp_if #(.CNT_W(5)) rsp_if ();

    keyed_response_holding_queue_core #(
        .DEPTH        (HOLD_DEPTH),
        .PAYLOAD_BITS (64)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sender idle / receiver stall percentages per traffic mode
    int unsigned send_idle_pct [4] = '{0, 63, 0, 19};
    int unsigned recv_stall_pct [4] = '{0, 0, 63, 19};

    req_item_t   pending_reqs [$];
    rsp_fields_t awaited_results [$];
    logic [31:0] issued_tags [$];
    req_item_t   cur_req;
    int unsigned rsp_stall_pct = 0;
    int          n_requests = 0;
    int          n_results = 0;
    int          n_fail = 0;

    // holding queue state as the block should see it
    logic [31:0] holding_tags [HOLD_DEPTH];
    logic [63:0] holding_pays [HOLD_DEPTH];
    int          holding_count = 0;
    logic [31:0] revision_now = 32'd1;

    function automatic rsp_fields_t apply_to_holding_queue(req_item_t r);
        rsp_fields_t e;
        int hit;
        int i;
        e.status = ST_OK;
        e.tag = '0;
        e.payload = '0;
        hit = -1;
        if (r.tag == 32'd0) begin
            e.status = ST_INVALID;
        end else if (r.op == OP_PUSH) begin
            if (!r.is_resp) begin
                e.status = ST_INVALID;
            end else if (holding_count >= HOLD_DEPTH) begin
                e.status = ST_FULL;
            end else begin
                holding_tags[holding_count] = r.tag;
                holding_pays[holding_count] = r.payload;
                holding_count++;
                revision_now++;
            end
        end else begin
            for (i = 0; i < holding_count; i++) begin
                if (hit < 0 && holding_tags[i] == r.tag) hit = i;
            end
            if (hit < 0) begin
                e.status = ST_NOT_FOUND;
            end else begin
                e.tag = holding_tags[hit];
                e.payload = holding_pays[hit];
                for (i = hit; i + 1 < holding_count; i++) begin
                    holding_tags[i] = holding_tags[i + 1];
                    holding_pays[i] = holding_pays[i + 1];
                end
                holding_count--;
                holding_tags[holding_count] = '0;
                holding_pays[holding_count] = '0;
                revision_now++;
            end
        end
        e.count = holding_count[4:0];
        e.revision = revision_now;
        return e;
    endfunction

    // appends a request and tracks which tags the queue will hold
    function automatic void queue_req(logic op, logic [31:0] tag, logic is_resp,
                                      logic [63:0] payload, int unsigned mode, bit drain);
        req_item_t r;
        int i;
        int hit;
        r.op = op;
        r.tag = tag;
        r.is_resp = is_resp;
        r.payload = payload;
        r.mode = mode;
        r.drain = drain;
        pending_reqs.push_back(r);
        hit = -1;
        if (tag != 32'd0) begin
            if (op == OP_PUSH) begin
                if (is_resp && issued_tags.size() < HOLD_DEPTH) issued_tags.push_back(tag);
            end else begin
                for (i = 0; i < issued_tags.size(); i++) begin
                    if (hit < 0 && issued_tags[i] == tag) hit = i;
                end
                if (hit >= 0) issued_tags.delete(hit);
            end
        end
    endfunction

    function automatic logic [31:0] fresh_tag();
        logic [31:0] t;
        t = $urandom;
        if (t == 32'd0) t = 32'd1;
        return t;
    endfunction

    function automatic logic [63:0] rand_payload();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return '1;
        if (pick < 15) return '0;
        return {$urandom, $urandom};
    endfunction

    always @(posedge i_clk) begin : drive_requests
        bit accepted;
        bit next_valid;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            accepted = req_if.valid && req_if.ready;
            if (accepted) begin
                awaited_results.push_back(apply_to_holding_queue(cur_req));
                n_requests <= n_requests + 1;
            end
            next_valid = req_if.valid && !accepted;
            if (!next_valid && pending_reqs.size() != 0) begin
                if (pending_reqs[0].drain && (accepted || n_requests != n_results)) begin
                    // hold off until every outstanding request has answered
                end else if ($urandom_range(99) >= send_idle_pct[pending_reqs[0].mode]) begin
                    cur_req = pending_reqs.pop_front();
                    next_valid = 1'b1;
                    req_if.operation <= cur_req.op;
                    req_if.sequence_tag <= cur_req.tag;
                    req_if.is_response <= cur_req.is_resp;
                    req_if.payload <= cur_req.payload;
                    rsp_stall_pct <= recv_stall_pct[cur_req.mode];
                end
            end
            req_if.valid <= next_valid;
        end
    end

    always @(posedge i_clk) begin : check_results
        rsp_fields_t want;
        rsp_fields_t got;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                n_results <= n_results + 1;
                got.status = t_status'(rsp_if.status);
                got.tag = rsp_if.taken_tag;
                got.payload = rsp_if.taken_payload;
                got.count = rsp_if.entry_count;
                got.revision = rsp_if.revision_out;
                if (awaited_results.size() == 0) begin
                    if (n_fail < 10)
                        $display("unexpected result: st=%0d tag=%h pay=%h cnt=%0d rev=%0d",
                                 got.status, got.tag, got.payload, got.count, got.revision);
                    n_fail++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.tag !== want.tag ||
                        got.payload !== want.payload || got.count !== want.count ||
                        got.revision !== want.revision) begin
                        if (n_fail < 10) begin
                            $display("mismatch exp: st=%0d tag=%h pay=%h cnt=%0d rev=%0d",
                                     want.status, want.tag, want.payload, want.count,
                                     want.revision);
                            $display("         got: st=%0d tag=%h pay=%h cnt=%0d rev=%0d",
                                     got.status, got.tag, got.payload, got.count,
                                     got.revision);
                        end
                        n_fail++;
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    initial begin : stimulus
        int counted;
        int seg;
        int k;
        int unsigned pick;
        int unsigned mode;
        bit first;
        bit filling;
        bit do_push;
        logic [31:0] tag;

        req_if.valid = 1'b0;
        req_if.operation = OP_PUSH;
        req_if.sequence_tag = '0;
        req_if.is_response = 1'b0;
        req_if.payload = '0;
        rsp_if.ready = 1'b0;

        // directed: empty take, invalid forms, duplicates, full store
        queue_req(OP_TAKE, 32'd5, 1'b1, '0, 0, 0);
        queue_req(OP_PUSH, 32'd0, 1'b1, '1, 0, 0);
        queue_req(OP_TAKE, 32'd0, 1'b0, '0, 0, 0);
        queue_req(OP_PUSH, 32'd7, 1'b0, 64'h1234, 0, 0);
        queue_req(OP_PUSH, 32'hFFFF_FFFF, 1'b1, '1, 0, 0);
        queue_req(OP_PUSH, 32'd1, 1'b1, '0, 0, 0);
        queue_req(OP_PUSH, 32'd7, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0);
        queue_req(OP_PUSH, 32'd7, 1'b1, 64'h5555_5555_5555_5555, 0, 0);
        queue_req(OP_TAKE, 32'd7, 1'b0, '1, 0, 0);
        for (k = 0; k < 13; k++)
            queue_req(OP_PUSH, 32'h8000_0000 | k, 1'b1, {$urandom, $urandom}, 0, 0);
        queue_req(OP_PUSH, 32'd9, 1'b0, '0, 0, 0);
        queue_req(OP_PUSH, 32'd9, 1'b1, '1, 0, 0);
        queue_req(OP_TAKE, 32'd1, 1'b1, '0, 0, 0);
        queue_req(OP_TAKE, 32'hFFFF_FFFF, 1'b1, '0, 0, 0);

        counted = 0;
        seg = 0;
        filling = 1'b1;
        while (counted < RANDOM_ITEMS) begin
            mode = seg % 4;
            first = 1'b1;
            for (k = 0; k < SEGMENT_ITEMS && counted < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(99);
                counted++;
                if (pick < 4) begin
                    queue_req($urandom_range(1) ? OP_TAKE : OP_PUSH, 32'd0, $urandom_range(1),
                              rand_payload(), mode, first);
                end else if (pick < 8) begin
                    queue_req(OP_PUSH, fresh_tag(), 1'b0, rand_payload(), mode, first);
                end else begin
                    if (pick < 12) begin
                        queue_req(OP_TAKE, fresh_tag(), $urandom_range(1), rand_payload(),
                                  mode, first);
                    end else begin
                        if (issued_tags.size() == HOLD_DEPTH && $urandom_range(3) == 0)
                            filling = 1'b0;
                        if (issued_tags.size() == 0) filling = 1'b1;
                        do_push = filling ? ($urandom_range(99) < 75)
                                          : ($urandom_range(99) < 25);
                        if (issued_tags.size() != 0 && (!do_push || $urandom_range(3) == 0))
                            tag = issued_tags[$urandom_range(issued_tags.size() - 1)];
                        else
                            tag = fresh_tag();
                        queue_req(do_push ? OP_PUSH : OP_TAKE, tag, do_push ? 1'b1 : 1'(
                                  $urandom_range(1)), rand_payload(), mode, first);
                    end
                end
                first = 1'b0;
            end
            seg++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || req_if.valid || n_requests != n_results);
        repeat (8) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            $display("%0d expected results never arrived", awaited_results.size());
            n_fail += awaited_results.size();
        end

        if (n_fail == 0)
            $display("keyed_response_holding_queue_core regression: pass");
        else
            $display("keyed_response_holding_queue_core regression: fail");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("keyed_response_holding_queue_core regression: fail");
        $finish;
    end

endmodule
